// ----- sv/lccd_pkg.sv -----
package lccd_pkg;

    localparam int VALUE_W = 12;
    localparam int MOD_W   = 12;
    localparam int BITS_W  = 4;
    // remainder of the long division by 2q, with 2q at most 8190
    localparam int REM_W   = MOD_W + 1;
    localparam int STEPS_PER_STAGE = 4;

    localparam logic [MOD_W-1:0]  MOD_RESET = 12'd3329;
    localparam logic [MOD_W-1:0]  MOD_MIN   = 12'd2;
    localparam logic [BITS_W-1:0] BITS_MIN  = 4'd1;
    localparam logic [BITS_W-1:0] BITS_MAX  = 4'd11;

    typedef enum logic {
        KIND_COMPRESS   = 1'b0,
        KIND_DECOMPRESS = 1'b1
    } t_kind;

    // per-beat side information that rides along the divider stages
    typedef struct packed {
        t_kind               kind;
        logic [BITS_W-1:0]   bits;
        logic [VALUE_W-1:0]  dec;
    } t_side;

endpackage

// ----- sv/lccd_if.sv -----
interface lccd_in_if #(
    parameter int COEFF_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COEFF_BITS-1:0] coeff;
    logic [3:0]            bits;

    modport source (output valid, output kind, output coeff, output bits, input ready);
    modport sink   (input valid, input kind, input coeff, input bits, output ready);
endinterface

interface lccd_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- sv/lccd_div_stage.sv -----
module lccd_div_stage #(
    parameter int NUM_W = 28
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [NUM_W-1:0]         i_num,
    input  logic [lccd_pkg::REM_W-1:0] i_rem,
    input  lccd_pkg::t_side          i_side,
    input  logic [lccd_pkg::REM_W-1:0] i_div,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [NUM_W-1:0]         o_num,
    output logic [lccd_pkg::REM_W-1:0] o_rem,
    output lccd_pkg::t_side          o_side
);

    logic                          r_valid;
    logic [NUM_W-1:0]              r_num;
    logic [lccd_pkg::REM_W-1:0]    r_rem;
    lccd_pkg::t_side               r_side;
    logic [NUM_W-1:0]              n_num;
    logic [lccd_pkg::REM_W-1:0]    n_rem;

    // restoring division: the dividend shifts out at the top, quotient bits enter at the bottom
    always_comb begin
        logic [lccd_pkg::REM_W:0] trial;
        n_num = i_num;
        n_rem = i_rem;
        for (int s = 0; s < lccd_pkg::STEPS_PER_STAGE; s++) begin
            trial = {n_rem, n_num[NUM_W-1]};
            n_num = {n_num[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, i_div}) begin
                trial    = trial - {1'b0, i_div};
                n_num[0] = 1'b1;
            end
            n_rem = trial[lccd_pkg::REM_W-1:0];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_side  = r_side;

endmodule

// ----- sv/lattice_coeff_compress_decompress_unit.sv -----
// Kyber-style coefficient compress / decompress. One coefficient beat is taken per cycle while the
// pipeline does not stall; every beat gives exactly one result beat, in order. The pipeline is
// an input register that forms the shifted numerator or the product x*q, NS restoring-divider
// stages, NS = ceil((COEFF_BITS + 13) / 4), that each retire four quotient bits of the division
// by 2q, and an output register. Compress gives
// round(x*2^d/q) mod 2^d, decompress round(x*q/2^d) saturated to the coefficient range, both
// with ties rounded up. A modulus below 2 acts as 2, and d is clamped to 1..11. The modulus
// register is written through i_cfg_we / i_cfg_wdata and must only change while no beat is
// in flight.
module lattice_coeff_compress_decompress_unit #(
    parameter int COEFF_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lccd_pkg::MOD_W-1:0]  i_cfg_wdata,
    lccd_in_if.sink                     i_in,
    lccd_out_if.source                  o_out
);

    localparam int NW  = COEFF_BITS + 13;
    localparam int NS  = (NW + lccd_pkg::STEPS_PER_STAGE - 1) / lccd_pkg::STEPS_PER_STAGE;
    localparam int NWP = NS * lccd_pkg::STEPS_PER_STAGE;
    localparam logic [NW-1:0] COEFF_MAX = NW'((64'd1 << COEFF_BITS) - 64'd1);

    logic [lccd_pkg::MOD_W-1:0]  r_modulus;
    logic [lccd_pkg::MOD_W-1:0]  q_eff;
    logic [lccd_pkg::REM_W-1:0]  div_2q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= lccd_pkg::MOD_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    assign q_eff  = (r_modulus < lccd_pkg::MOD_MIN) ? lccd_pkg::MOD_MIN : r_modulus;
    assign div_2q = {q_eff, 1'b0};

    // input stage: numerator for compress, product for decompress
    logic [lccd_pkg::BITS_W-1:0]   d_eff;
    logic [COEFF_BITS+11:0]        prod;
    logic [NW-1:0]                 num;
    logic [NW-1:0]                 n_work;

    always_comb begin
        if (i_in.bits < lccd_pkg::BITS_MIN) begin
            d_eff = lccd_pkg::BITS_MIN;
        end else if (i_in.bits > lccd_pkg::BITS_MAX) begin
            d_eff = lccd_pkg::BITS_MAX;
        end else begin
            d_eff = i_in.bits;
        end
    end

    assign prod   = i_in.coeff * q_eff;
    assign num    = (NW'(i_in.coeff) << (d_eff + 4'd1)) + NW'(q_eff);
    assign n_work = (i_in.kind == lccd_pkg::KIND_DECOMPRESS) ? NW'(prod) : num;

    logic                          r_ent_valid;
    logic [NW-1:0]                 r_work;
    lccd_pkg::t_kind               r_ent_kind;
    logic [lccd_pkg::BITS_W-1:0]   r_ent_bits;
    logic                          ent_ready;

    logic                          s_valid [NS+1];
    logic                          s_ready [NS+1];
    logic [NWP-1:0]                s_num   [NS+1];
    logic [lccd_pkg::REM_W-1:0]    s_rem   [NS+1];
    lccd_pkg::t_side               s_side  [NS+1];

    assign ent_ready   = !r_ent_valid || s_ready[0];
    assign i_in.ready  = ent_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= 1'b0;
        end else if (ent_ready) begin
            r_ent_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_ready && i_in.valid) begin
            r_work     <= n_work;
            r_ent_kind <= lccd_pkg::t_kind'(i_in.kind);
            r_ent_bits <= d_eff;
        end
    end

    // decompress rounding and saturation, finished before the divider stages
    logic [NW-1:0] dec_sum;
    logic [NW-1:0] dec_shr;
    logic [NW-1:0] dec_sat;

    assign dec_sum = r_work + (NW'(1) << (r_ent_bits - 4'd1));
    assign dec_shr = dec_sum >> r_ent_bits;
    assign dec_sat = (dec_shr > COEFF_MAX) ? COEFF_MAX : dec_shr;

    assign s_valid[0]     = r_ent_valid;
    assign s_num[0]       = NWP'(r_work);
    assign s_rem[0]       = '0;
    assign s_side[0].kind = r_ent_kind;
    assign s_side[0].bits = r_ent_bits;
    assign s_side[0].dec  = dec_sat[lccd_pkg::VALUE_W-1:0];

    for (genvar k = 0; k < NS; k++) begin : g_div
        lccd_div_stage #(
            .NUM_W (NWP)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_num   (s_num[k]),
            .i_rem   (s_rem[k]),
            .i_side  (s_side[k]),
            .i_div   (div_2q),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_num   (s_num[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_side  (s_side[k+1])
        );
    end

    // output register
    logic                          r_out_valid;
    logic [lccd_pkg::VALUE_W-1:0]  r_out_value;
    logic [lccd_pkg::VALUE_W-1:0]  n_out_value;
    logic [lccd_pkg::VALUE_W-1:0]  cmp_mask;

    assign s_ready[NS] = !r_out_valid || o_out.ready;
    assign cmp_mask    = (lccd_pkg::VALUE_W'(1) << s_side[NS].bits) - lccd_pkg::VALUE_W'(1);
    assign n_out_value = (s_side[NS].kind == lccd_pkg::KIND_DECOMPRESS)
                       ? s_side[NS].dec
                       : (s_num[NS][lccd_pkg::VALUE_W-1:0] & cmp_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_ready[NS]) begin
            r_out_valid <= s_valid[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready[NS] && s_valid[NS]) begin
            r_out_value <= n_out_value;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;

    // quotient remainders are only carried between stages
    logic unused_rem;
    assign unused_rem = ^s_rem[NS];

endmodule

// ----- sv/lccd_checker.sv -----
module lccd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_out_value
);

    logic       in_beat;
    logic       out_beat;
    logic [7:0] r_cnt;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // beats taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_beat && !out_beat) begin
            r_cnt <= r_cnt + 8'd1;
        end else if (out_beat && !in_beat) begin
            r_cnt <= r_cnt - 8'd1;
        end
    end

    a_out_needs_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> r_cnt != 8'd0)
        else $error("result beat with no coefficient beat outstanding");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_value))
        else $error("result value changed while stalled");

endmodule

bind lattice_coeff_compress_decompress_unit lccd_checker u_lccd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value)
);

// ----- tb/sv/testbench.sv -----
module testbench;

    localparam int COEFF_BITS    = 12;
    localparam int COEFF_MAX     = (1 << COEFF_BITS) - 1;
    // extra idle time after the last owed result, as margin
    localparam int DRAIN_CYCLES  = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_CHUNKS = 13;
    localparam int CHUNK_ITEMS   = 125;
    localparam int PRESSURE_ITEMS = 60;

    typedef struct {
        lccd_pkg::t_kind                 kind;
        logic [COEFF_BITS-1:0]           coeff;
        logic [lccd_pkg::BITS_W-1:0]     bits_raw;
        logic [lccd_pkg::VALUE_W-1:0]    value;
    } t_conv;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [lccd_pkg::MOD_W-1:0]   i_cfg_wdata;

    lccd_in_if #(.COEFF_BITS(COEFF_BITS)) coeff_in ();
    lccd_out_if                           value_out ();

    lattice_coeff_compress_decompress_unit #(
        .COEFF_BITS(COEFF_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (coeff_in.sink),
        .o_out       (value_out.source)
    );

    // testbench copy of the modulus register and the results still owed
    logic [lccd_pkg::MOD_W-1:0] modulus_q;
    t_conv                      owed_q[$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_cycles = 0;

    int sent_count = 0;
    int checked_count = 0;
    int cfg_writes = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    function automatic logic [lccd_pkg::VALUE_W-1:0] convert_coeff(lccd_pkg::t_kind kind,
            logic [COEFF_BITS-1:0] x, logic [lccd_pkg::BITS_W-1:0] bits_raw,
            logic [lccd_pkg::MOD_W-1:0] mod_q);
        int unsigned q;
        int unsigned d;
        int unsigned xi;
        int unsigned r;
        q  = 32'((mod_q < lccd_pkg::MOD_MIN) ? lccd_pkg::MOD_MIN : mod_q);
        d  = 32'((bits_raw < lccd_pkg::BITS_MIN) ? lccd_pkg::BITS_MIN
                 : (bits_raw > lccd_pkg::BITS_MAX) ? lccd_pkg::BITS_MAX : bits_raw);
        xi = 32'(x);
        if (kind == lccd_pkg::KIND_COMPRESS) begin
            // ties go up: floor((x*2^(d+1) + q) / 2q), wrapped to d bits
            r = ((xi << (d + 1)) + q) / (2 * q);
            r = r & ((32'd1 << d) - 1);
        end else begin
            r = (xi * q + (32'd1 << (d - 1))) >> d;
            if (r > COEFF_MAX) begin
                r = COEFF_MAX;
            end
        end
        return r[lccd_pkg::VALUE_W-1:0];
    endfunction

    task automatic send_coeff(lccd_pkg::t_kind kind, logic [COEFF_BITS-1:0] coeff,
            logic [lccd_pkg::BITS_W-1:0] bits_raw);
        int    gap;
        t_conv item;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            coeff_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        coeff_in.valid <= 1'b1;
        coeff_in.kind  <= kind;
        coeff_in.coeff <= coeff;
        coeff_in.bits  <= bits_raw;
        do @(posedge i_clk); while (coeff_in.ready !== 1'b1);
        item.kind     = kind;
        item.coeff    = coeff;
        item.bits_raw = bits_raw;
        item.value    = convert_coeff(kind, coeff, bits_raw, modulus_q);
        owed_q.push_back(item);
        sent_count++;
    endtask

    task automatic drain_block();
        @(negedge i_clk);
        coeff_in.valid <= 1'b0;
        while (owed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_modulus(logic [lccd_pkg::MOD_W-1:0] mod_val);
        drain_block();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mod_val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        modulus_q = mod_val;
        cfg_writes++;
    endtask

    // reset modulus: range extremes, bit count clamping, saturation
    task automatic test_reset_modulus();
        send_coeff(lccd_pkg::KIND_COMPRESS, 12'd0, 4'd1);
        send_coeff(lccd_pkg::KIND_COMPRESS, 12'd4095, 4'd11);
        send_coeff(lccd_pkg::KIND_COMPRESS, 12'd3328, 4'd11);
        send_coeff(lccd_pkg::KIND_COMPRESS, 12'd3329, 4'd4);
        send_coeff(lccd_pkg::KIND_COMPRESS, 12'd833, 4'd1);
        send_coeff(lccd_pkg::KIND_COMPRESS, 12'd1665, 4'd0);
        send_coeff(lccd_pkg::KIND_COMPRESS, 12'd1000, 4'd15);
        send_coeff(lccd_pkg::KIND_COMPRESS, 12'd2000, 4'd12);
        send_coeff(lccd_pkg::KIND_DECOMPRESS, 12'd0, 4'd1);
        send_coeff(lccd_pkg::KIND_DECOMPRESS, 12'd1, 4'd1);
        send_coeff(lccd_pkg::KIND_DECOMPRESS, 12'd2047, 4'd11);
        send_coeff(lccd_pkg::KIND_DECOMPRESS, 12'd4095, 4'd1);
        send_coeff(lccd_pkg::KIND_DECOMPRESS, 12'd4095, 4'd11);
        send_coeff(lccd_pkg::KIND_DECOMPRESS, 12'd3, 4'd0);
        send_coeff(lccd_pkg::KIND_DECOMPRESS, 12'd100, 4'd15);
    endtask

    // moduli below the floor, the largest one, and an even one
    task automatic test_modulus_extremes();
        write_modulus(12'd0);
        send_coeff(lccd_pkg::KIND_COMPRESS, 12'd1, 4'd1);
        send_coeff(lccd_pkg::KIND_DECOMPRESS, 12'd1, 4'd1);
        write_modulus(12'd1);
        send_coeff(lccd_pkg::KIND_COMPRESS, 12'd4095, 4'd11);
        send_coeff(lccd_pkg::KIND_DECOMPRESS, 12'd2047, 4'd11);
        write_modulus(12'd4095);
        send_coeff(lccd_pkg::KIND_COMPRESS, 12'd4095, 4'd11);
        send_coeff(lccd_pkg::KIND_DECOMPRESS, 12'd4095, 4'd11);
        // even modulus gives an exact tie in compress
        write_modulus(12'd4);
        send_coeff(lccd_pkg::KIND_COMPRESS, 12'd1, 4'd1);
    endtask

    task automatic test_random_traffic();
        logic [lccd_pkg::MOD_W-1:0]  mod_val;
        logic [lccd_pkg::BITS_W-1:0] bits_raw;
        logic [COEFF_BITS-1:0]       coeff;
        int unsigned                 q_eff;
        int unsigned                 d_eff;
        lccd_pkg::t_kind             kind;
        for (int c = 0; c < RANDOM_CHUNKS; c++) begin
            case (c)
                0: mod_val = lccd_pkg::MOD_RESET;
                1: mod_val = 12'd4095;
                2: mod_val = 12'd2;
                3: mod_val = 12'd0;
                4: mod_val = 12'd1;
                5: mod_val = 12'd3;
                default: mod_val = 12'($urandom_range(0, COEFF_MAX));
            endcase
            write_modulus(mod_val);
            q_eff = 32'((mod_val < lccd_pkg::MOD_MIN) ? lccd_pkg::MOD_MIN : mod_val);
            case ($urandom_range(0, 3))
                0: begin tx_idle_on = 1'b1; rx_idle_on = 1'b1; end
                1: begin tx_idle_on = 1'b1; rx_idle_on = 1'b0; end
                2: begin tx_idle_on = 1'b0; rx_idle_on = 1'b1; end
                default: begin tx_idle_on = 1'b0; rx_idle_on = 1'b0; end
            endcase
            for (int i = 0; i < CHUNK_ITEMS; i++) begin
                kind     = lccd_pkg::t_kind'($urandom_range(0, 1));
                bits_raw = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(1, 11));
                d_eff = 32'((bits_raw < lccd_pkg::BITS_MIN) ? lccd_pkg::BITS_MIN
                      : (bits_raw > lccd_pkg::BITS_MAX) ? lccd_pkg::BITS_MAX : bits_raw);
                case ($urandom_range(0, 3))
                    0: coeff = 12'($urandom_range(0, COEFF_MAX));
                    1: coeff = 12'($urandom_range(0, q_eff - 1));
                    2: coeff = 12'($urandom_range(0, (1 << d_eff) - 1));
                    default: begin
                        case ($urandom_range(0, 5))
                            0: coeff = '0;
                            1: coeff = 12'(q_eff - 1);
                            2: coeff = 12'(q_eff);
                            3: coeff = 12'(COEFF_MAX);
                            4: coeff = 12'((1 << d_eff) - 1);
                            default: coeff = 12'(1 << d_eff);
                        endcase
                    end
                endcase
                send_coeff(kind, coeff, bits_raw);
            end
        end
    endtask

    // long receiver hold while beats keep coming, so the input has to stall
    task automatic test_backpressure();
        write_modulus(lccd_pkg::MOD_RESET);
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < PRESSURE_ITEMS; i++) begin
            send_coeff(lccd_pkg::t_kind'($urandom_range(0, 1)),
                       12'($urandom_range(0, COEFF_MAX)), 4'($urandom_range(0, 15)));
        end
    endtask

    initial begin : result_sink
        int stall;
        value_out.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 11) : 0;
            end
            if (stall > 0) begin
                value_out.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            value_out.ready <= 1'b1;
            do @(posedge i_clk); while (value_out.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_conv want;
        if (i_rst_n === 1'b1 && value_out.valid === 1'b1 && value_out.ready === 1'b1) begin
            checked_count++;
            if (owed_q.size() == 0) begin
                fail_count++;
                $display("%0t: result beat with nothing owed: expected none, got %0d",
                         $time, value_out.value);
            end else begin
                want = owed_q.pop_front();
                if (value_out.value !== want.value) begin
                    fail_count++;
                    $display("%0t: %s coeff %0d bits %0d: expected %0d, got %0d", $time,
                             want.kind.name(), want.coeff, want.bits_raw, want.value,
                             value_out.value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((coeff_in.valid === 1'b1 && coeff_in.ready === 1'b1) ||
                (value_out.valid === 1'b1 && value_out.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results owed", $time,
                         quiet_cycles, owed_q.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        coeff_in.valid = 1'b0;
        coeff_in.kind  = lccd_pkg::KIND_COMPRESS;
        coeff_in.coeff = '0;
        coeff_in.bits  = '0;
        modulus_q      = lccd_pkg::MOD_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_modulus();
        test_modulus_extremes();
        test_random_traffic();
        test_backpressure();
        drain_block();

        $display("%0d coefficients sent, %0d results checked, %0d modulus writes",
                 sent_count, checked_count, cfg_writes);
        $display("both directions, bit counts 0..15, moduli 0/1/2/4095 and random, idle gaps");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
